### hdl/bws_pkg.sv
// ----------------------------------------------------------------------------
// bws_pkg: shared types and fixed-point helpers
// Q16.16 values held in 64 bits, saturating add/sub, per-item context record.
// ----------------------------------------------------------------------------
package bws_pkg;

  localparam int NMUL      = 6;   // product lanes per multiplier unit
  localparam int DIV_STEPS = 80;  // quotient bits produced by the divider
  localparam int SQ_STEPS  = 40;  // root bits produced by the square root

  typedef logic signed [63:0] q_t;

  localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t QMIN = 64'sh8000_0000_0000_0000;
  localparam q_t ONE  = 64'sd65536;

  // live values of one item as it moves down the pipeline
  typedef struct packed {
    q_t   px, py, vx, vy, cx, cy, nx, ny, dt;
    q_t   wx, wy, ax, ay, cdx, cdy, test, rsq;
    q_t   cdlen, qa, t, f, sx, sy, k, qd, prm;
    logic ins;
  } ctx_t;

  function automatic q_t sx32(logic [31:0] d);
    return {{32{d[31]}}, d};
  endfunction

  function automatic q_t addq(q_t a, q_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
    return s[63:0];
  endfunction

  function automatic q_t subq(q_t a, q_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
    return s[63:0];
  endfunction

  function automatic q_t negq(q_t a);
    return (a == QMIN) ? QMAX : -a;
  endfunction

  function automatic logic [63:0] mag(q_t a);
    return a[63] ? (~a) + 64'd1 : a;
  endfunction

  function automatic q_t from_mag(logic [63:0] m, logic neg);
    if (neg) return m[63] ? QMIN : -m;
    return m[63] ? QMAX : m;
  endfunction

endpackage

### hdl/bws_mul.sv
// ----------------------------------------------------------------------------
// bws_mul: saturating Q16.16 multiplier lanes
// Five stages: magnitudes, 32x32 partial products, middle sum, full sum,
// scale and saturate. Context record travels alongside.
// ----------------------------------------------------------------------------
module bws_mul import bws_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ctx_t                 ctx_i,
  input  q_t [NMUL-1:0]        a_i,
  input  q_t [NMUL-1:0]        b_i,
  output logic                 valid_o,
  output ctx_t                 ctx_o,
  output q_t [NMUL-1:0]        p_o
);

  logic [4:0] v_q;
  ctx_t       c_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= ctx_i;
      for (int i = 1; i < 5; i++) c_q[i] <= c_q[i-1];
    end
  end

  for (genvar j = 0; j < NMUL; j++) begin : g_lane
    logic [63:0]  ma_q, mb_q;
    logic [63:0]  ll_q, lh_q, hl_q, hh_q;
    logic [63:0]  ll2_q, hh2_q;
    logic [64:0]  mid_q;
    logic [127:0] p_q;
    logic [3:0]   ng_q;
    q_t           r_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ma_q    <= mag(a_i[j]);
        mb_q    <= mag(b_i[j]);
        ng_q[0] <= a_i[j][63] ^ b_i[j][63];
        ll_q    <= ma_q[31:0]  * mb_q[31:0];
        lh_q    <= ma_q[31:0]  * mb_q[63:32];
        hl_q    <= ma_q[63:32] * mb_q[31:0];
        hh_q    <= ma_q[63:32] * mb_q[63:32];
        ng_q[1] <= ng_q[0];
        mid_q   <= {1'b0, lh_q} + {1'b0, hl_q};
        ll2_q   <= ll_q;
        hh2_q   <= hh_q;
        ng_q[2] <= ng_q[1];
        p_q     <= {hh2_q, ll2_q} + {31'd0, mid_q, 32'd0};
        ng_q[3] <= ng_q[2];
        r_q     <= from_mag((p_q[127:80] != '0) ? '1 : p_q[79:16], ng_q[3]);
      end
    end

    assign p_o[j] = r_q;
  end

  assign valid_o = v_q[4];
  assign ctx_o   = c_q[4];

endmodule

### hdl/bws_div.sv
// ----------------------------------------------------------------------------
// bws_div: pipelined saturating Q16.16 divider
// One restoring step per stage over the 80-bit scaled dividend; a zero
// divisor yields zero.
// ----------------------------------------------------------------------------
module bws_div import bws_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  ctx_t  ctx_i,
  input  q_t    a_i,
  input  q_t    b_i,
  output logic  valid_o,
  output ctx_t  ctx_o,
  output q_t    q_o
);

  logic [DIV_STEPS+1:0] v_q;
  logic [63:0]          r_q  [DIV_STEPS+1];
  logic [79:0]          n_q  [DIV_STEPS+1];
  logic [79:0]          q_q  [DIV_STEPS+1];
  logic [63:0]          ub_q [DIV_STEPS+1];
  logic                 ng_q [DIV_STEPS+1];
  logic                 bz_q [DIV_STEPS+1];
  ctx_t                 c_q  [DIV_STEPS+1];
  ctx_t                 co_q;
  q_t                   qo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STEPS:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= '0;
      n_q[0]  <= {mag(a_i), 16'd0};
      q_q[0]  <= '0;
      ub_q[0] <= mag(b_i);
      ng_q[0] <= a_i[63] ^ b_i[63];
      bz_q[0] <= (b_i == '0);
      c_q[0]  <= ctx_i;
    end
  end

  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    logic [63:0] rr;
    logic        ge;

    always_comb begin
      rr = {r_q[s-1][62:0], n_q[s-1][79]};
      ge = (rr >= ub_q[s-1]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]  <= ge ? rr - ub_q[s-1] : rr;
        n_q[s]  <= {n_q[s-1][78:0], 1'b0};
        q_q[s]  <= {q_q[s-1][78:0], ge};
        ub_q[s] <= ub_q[s-1];
        ng_q[s] <= ng_q[s-1];
        bz_q[s] <= bz_q[s-1];
        c_q[s]  <= c_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      co_q <= c_q[DIV_STEPS];
      if (bz_q[DIV_STEPS]) begin
        qo_q <= '0;
      end else begin
        qo_q <= from_mag((q_q[DIV_STEPS][79:64] != '0) ? '1 : q_q[DIV_STEPS][63:0],
                         ng_q[DIV_STEPS]);
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS+1];
  assign ctx_o   = co_q;
  assign q_o     = qo_q;

endmodule

### hdl/bws_sqrt.sv
// ----------------------------------------------------------------------------
// bws_sqrt: pipelined square root, floor(sqrt(x * 2^16))
// Digit-by-digit, one root bit per stage; input must be non-negative.
// ----------------------------------------------------------------------------
module bws_sqrt import bws_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  ctx_t  ctx_i,
  input  q_t    x_i,
  output logic  valid_o,
  output ctx_t  ctx_o,
  output q_t    s_o
);

  logic [SQ_STEPS+1:0] v_q;
  logic [79:0]         rad_q [SQ_STEPS+1];
  logic [43:0]         rem_q [SQ_STEPS+1];
  logic [39:0]         rt_q  [SQ_STEPS+1];
  ctx_t                c_q   [SQ_STEPS+1];
  ctx_t                co_q;
  q_t                  so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SQ_STEPS:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0] <= {1'b0, x_i[62:0], 16'd0};
      rem_q[0] <= '0;
      rt_q[0]  <= '0;
      c_q[0]   <= ctx_i;
    end
  end

  for (genvar s = 1; s <= SQ_STEPS; s++) begin : g_step
    logic [43:0] rm, tr;
    logic        ge;

    always_comb begin
      rm = {rem_q[s-1][41:0], rad_q[s-1][79:78]};
      tr = {2'b00, rt_q[s-1], 2'b01};
      ge = (rm >= tr);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rm - tr : rm;
        rt_q[s]  <= {rt_q[s-1][38:0], ge};
        rad_q[s] <= {rad_q[s-1][77:0], 2'b00};
        c_q[s]   <= c_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      co_q <= c_q[SQ_STEPS];
      so_q <= {24'd0, rt_q[SQ_STEPS]};
    end
  end

  assign valid_o = v_q[SQ_STEPS+1];
  assign ctx_o   = co_q;
  assign s_o     = so_q;

endmodule

### hdl/ball_wall_sweep_test.sv
// ----------------------------------------------------------------------------
// ball_wall_sweep_test: swept ball against wall segment, Q16.16
// Contact time against the wall line, projection onto the segment, and a
// ray-circle retest from the nearest segment point.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       11 x 32-bit ball/wall/step
// m_axis    out        m_axis_tvalid/tready       collides, hit_time
// cfg       in         cfg_valid_i/cfg_ready_o    ball_radius (31 bits)
//
// One request per cycle unless the output stalls; the pipeline is nine 5-stage
// multiplier units, four 82-stage dividers, one 42-stage square root and one
// output register. The divider step chain sets the depth.
// Reset clears valid bits; radius returns to 1.0. A stalled output freezes the
// whole pipeline, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ball_wall_sweep_test import bws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ball_x, ball_y, vel_x, vel_y, seg_start_x, seg_start_y,
  // seg_end_x, seg_end_y, norm_x, norm_y, time_step (32 bits each)
  input  logic [351:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // collides [0], hit_time [32:1], zero fill [39:33]
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i
);

  logic        adv;
  logic [30:0] rad_q;
  logic        ov_q;
  logic [39:0] od_q;

  assign adv           = !ov_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= 31'd65536;
    end else if (cfg_valid_i) begin
      rad_q <= cfg_data_i;
    end
  end

  q_t rq;
  assign rq = {33'd0, rad_q};

  // unit interconnect
  ctx_t          n1, n2, n4, n5, n7, n8, n9, n12, n13;
  ctx_t          c1, c2, c4, c5, c7, c8, c9, c12, c13;
  ctx_t          n3, n6, n10, n11, n14, c3, c6, c10, c11, c14;
  q_t [NMUL-1:0] a1, b1, a2, b2, a4, b4, a5, b5, a7, b7, a8, b8, a9, b9;
  q_t [NMUL-1:0] a12, b12, a13, b13;
  q_t [NMUL-1:0] p1, p2, p4, p5, p7, p8, p9, p12, p13;
  q_t            da3, db3, da6, db6, da11, db11, da14, db14, sx10;
  q_t            q3, q6, q11, q14, s10;
  logic          v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14;

  // phase 1: unpack, radius offset, normal speed and radius square products
  always_comb begin
    n1     = '0;
    n1.px  = sx32(s_axis_tdata[31:0]);
    n1.py  = sx32(s_axis_tdata[63:32]);
    n1.vx  = sx32(s_axis_tdata[95:64]);
    n1.vy  = sx32(s_axis_tdata[127:96]);
    n1.cx  = sx32(s_axis_tdata[159:128]);
    n1.cy  = sx32(s_axis_tdata[191:160]);
    n1.nx  = sx32(s_axis_tdata[287:256]);
    n1.ny  = sx32(s_axis_tdata[319:288]);
    n1.dt  = sx32(s_axis_tdata[351:320]);
    n1.cdx = subq(sx32(s_axis_tdata[223:192]), n1.cx);
    n1.cdy = subq(sx32(s_axis_tdata[255:224]), n1.cy);
    n1.wx  = negq(n1.vx);
    n1.wy  = negq(n1.vy);
    a1 = '0; b1 = '0;
    a1[0] = n1.nx; b1[0] = negq(rq);
    a1[1] = n1.ny; b1[1] = negq(rq);
    a1[2] = n1.nx; b1[2] = n1.vx;
    a1[3] = n1.ny; b1[3] = n1.vy;
    a1[4] = rq;    b1[4] = rq;
  end

  bws_mul u_m1 (.clk_i, .rst_ni, .en_i(adv), .valid_i(s_axis_tvalid), .ctx_i(n1),
                .a_i(a1), .b_i(b1), .valid_o(v1), .ctx_o(c1), .p_o(p1));

  always_comb begin
    n2      = c1;
    n2.ax   = addq(c1.px, p1[0]);
    n2.ay   = addq(c1.py, p1[1]);
    n2.test = addq(p1[2], p1[3]);
    n2.rsq  = p1[4];
    a2 = '0; b2 = '0;
    a2[0] = c1.nx;  b2[0] = subq(c1.cx, n2.ax);
    a2[1] = c1.ny;  b2[1] = subq(c1.cy, n2.ay);
    a2[2] = c1.cdx; b2[2] = c1.cdx;
    a2[3] = c1.cdy; b2[3] = c1.cdy;
    a2[4] = c1.wx;  b2[4] = c1.wx;
    a2[5] = c1.wy;  b2[5] = c1.wy;
  end

  bws_mul u_m2 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v1), .ctx_i(n2),
                .a_i(a2), .b_i(b2), .valid_o(v2), .ctx_o(c2), .p_o(p2));

  // first contact time against the wall line
  always_comb begin
    n3       = c2;
    n3.cdlen = addq(p2[2], p2[3]);
    n3.qa    = addq(p2[4], p2[5]);
    da3      = addq(p2[0], p2[1]);
    db3      = c2.test;
  end

  bws_div u_d3 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v2), .ctx_i(n3),
                .a_i(da3), .b_i(db3), .valid_o(v3), .ctx_o(c3), .q_o(q3));

  always_comb begin
    n4   = c3;
    n4.t = q3;
    a4 = '0; b4 = '0;
    a4[0] = c3.vx; b4[0] = q3;
    a4[1] = c3.vy; b4[1] = q3;
  end

  bws_mul u_m4 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v3), .ctx_i(n4),
                .a_i(a4), .b_i(b4), .valid_o(v4), .ctx_o(c4), .p_o(p4));

  always_comb begin
    n5 = c4;
    a5 = '0; b5 = '0;
    a5[0] = subq(addq(p4[0], c4.ax), c4.cx); b5[0] = c4.cdx;
    a5[1] = subq(addq(p4[1], c4.ay), c4.cy); b5[1] = c4.cdy;
  end

  bws_mul u_m5 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v4), .ctx_i(n5),
                .a_i(a5), .b_i(b5), .valid_o(v5), .ctx_o(c5), .p_o(p5));

  // projection onto the segment
  always_comb begin
    n6  = c5;
    da6 = addq(p5[0], p5[1]);
    db6 = c5.cdlen;
  end

  bws_div u_d6 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v5), .ctx_i(n6),
                .a_i(da6), .b_i(db6), .valid_o(v6), .ctx_o(c6), .q_o(q6));

  always_comb begin
    n7 = c6;
    priority if (q6 < 0)   n7.f = '0;
    else if (q6 > ONE)     n7.f = ONE;
    else                   n7.f = q6;
    n7.ins = (n7.f > 0) && (n7.f < ONE) && (c6.t >= 0);
    a7 = '0; b7 = '0;
    a7[0] = c6.cdx; b7[0] = n7.f;
    a7[1] = c6.cdy; b7[1] = n7.f;
  end

  bws_mul u_m7 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v6), .ctx_i(n7),
                .a_i(a7), .b_i(b7), .valid_o(v7), .ctx_o(c7), .p_o(p7));

  // nearest segment point and ray-circle terms
  q_t rx8, ry8;
  always_comb begin
    n8    = c7;
    n8.sx = addq(c7.cx, p7[0]);
    n8.sy = addq(c7.cy, p7[1]);
    rx8   = subq(c7.px, n8.sx);
    ry8   = subq(c7.py, n8.sy);
    a8 = '0; b8 = '0;
    a8[0] = rx8; b8[0] = c7.wx;
    a8[1] = ry8; b8[1] = c7.wy;
    a8[2] = rx8; b8[2] = rx8;
    a8[3] = ry8; b8[3] = ry8;
  end

  bws_mul u_m8 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v7), .ctx_i(n8),
                .a_i(a8), .b_i(b8), .valid_o(v8), .ctx_o(c8), .p_o(p8));

  always_comb begin
    n9   = c8;
    n9.k = addq(p8[0], p8[1]);
    a9 = '0; b9 = '0;
    a9[0] = n9.k;  b9[0] = n9.k;
    a9[1] = c8.qa; b9[1] = subq(addq(p8[2], p8[3]), c8.rsq);
  end

  bws_mul u_m9 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v8), .ctx_i(n9),
                .a_i(a9), .b_i(b9), .valid_o(v9), .ctx_o(c9), .p_o(p9));

  always_comb begin
    n10    = c9;
    n10.qd = subq(p9[0], p9[1]);
    sx10   = n10.qd[63] ? '0 : n10.qd;
  end

  bws_sqrt u_s10 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v9), .ctx_i(n10),
                  .x_i(sx10), .valid_o(v10), .ctx_o(c10), .s_o(s10));

  always_comb begin
    n11  = c10;
    da11 = subq(c10.k, s10);
    db11 = c10.qa;
  end

  bws_div u_d11 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v10), .ctx_i(n11),
                 .a_i(da11), .b_i(db11), .valid_o(v11), .ctx_o(c11), .q_o(q11));

  always_comb begin
    n12     = c11;
    n12.prm = q11;
    a12 = '0; b12 = '0;
    a12[0] = c11.wx; b12[0] = q11;
    a12[1] = c11.wy; b12[1] = q11;
  end

  bws_mul u_m12 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v11), .ctx_i(n12),
                 .a_i(a12), .b_i(b12), .valid_o(v12), .ctx_o(c12), .p_o(p12));

  always_comb begin
    n13 = c12;
    a13 = '0; b13 = '0;
    a13[0] = c12.nx; b13[0] = subq(c12.cx, addq(c12.sx, p12[0]));
    a13[1] = c12.ny; b13[1] = subq(c12.cy, addq(c12.sy, p12[1]));
  end

  bws_mul u_m13 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v12), .ctx_i(n13),
                 .a_i(a13), .b_i(b13), .valid_o(v13), .ctx_o(c13), .p_o(p13));

  // retest contact time from the ray-circle point
  always_comb begin
    n14  = c13;
    da14 = addq(p13[0], p13[1]);
    db14 = c13.test;
  end

  bws_div u_d14 (.clk_i, .rst_ni, .en_i(adv), .valid_i(v13), .ctx_i(n14),
                 .a_i(da14), .b_i(db14), .valid_o(v14), .ctx_o(c14), .q_o(q14));

  // decision and 32-bit saturation
  q_t          tf;
  logic        hit;
  logic [31:0] t32;
  always_comb begin
    tf  = c14.t;
    hit = 1'b0;
    priority if (c14.t > c14.dt) begin
      hit = 1'b0;
    end else if (c14.cdlen == '0) begin
      hit = 1'b0;
    end else if (c14.ins) begin
      hit = 1'b1;
    end else if (c14.qd < 0 || c14.qa == '0) begin
      hit = 1'b0;
    end else if (c14.prm > ONE) begin
      hit = 1'b0;
    end else begin
      tf  = q14;
      hit = (q14 <= c14.dt) && (q14 >= 0);
    end
    priority if (tf > 64'sh7FFF_FFFF)       t32 = 32'h7FFF_FFFF;
    else if (tf < -64'sh8000_0000)          t32 = 32'h8000_0000;
    else                                    t32 = tf[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= v14;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) od_q <= {7'd0, t32, hit};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  // a hit always comes with a non-negative contact time
  a_hit_time_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[32])
    else $error("hit reported with negative time");

  // a stall holds the valid outputs of u_m1 and u_d3 steady
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v1) && $stable(v3))
    else $error("pipeline moved during stall");

  // fill bits of the result stay zero
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("nonzero fill in result");

endmodule
